>>> rtl/tcsd_pkg.sv
// tcsd_pkg: types and constants for the terminal command stream decoder
// no dependencies
`timescale 1ns / 1ps
package tcsd_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_IDLE    = 2'd1;
  localparam logic [1:0] OP_RESYNC  = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [3:0] K_CLEAR   = 4'd0;
  localparam logic [3:0] K_RUN     = 4'd1;
  localparam logic [3:0] K_FILL    = 4'd2;
  localparam logic [3:0] K_CURSOR  = 4'd3;
  localparam logic [3:0] K_GLYPH   = 4'd4;
  localparam logic [3:0] K_CLAIM   = 4'd5;
  localparam logic [3:0] K_PCELL   = 4'd6;
  localparam logic [3:0] K_FRAME   = 4'd7;
  localparam logic [3:0] K_BELL    = 4'd8;
  localparam logic [3:0] K_SHUT    = 4'd9;
  localparam logic [3:0] K_CONTROL = 4'd10;
  localparam logic [3:0] K_ANSWER  = 4'd11;

  localparam logic [7:0] CTL_RESYNC = 8'd1;
  localparam logic [7:0] CTL_CREDIT = 8'd3;

  localparam logic [7:0] OPC_CLEAR  = 8'h01;
  localparam logic [7:0] OPC_RUN    = 8'h02;
  localparam logic [7:0] OPC_FILL   = 8'h03;
  localparam logic [7:0] OPC_CURSOR = 8'h04;
  localparam logic [7:0] OPC_FRAME  = 8'h05;
  localparam logic [7:0] OPC_BELL   = 8'h06;
  localparam logic [7:0] OPC_PANEL  = 8'h07;
  localparam logic [7:0] OPC_HELLO  = 8'h08;
  localparam logic [7:0] OPC_BYE    = 8'h09;
  localparam logic [7:0] OPC_GLYPH  = 8'h0A;

  localparam logic [7:0] BYE_KEY    = 8'h5A;
  localparam logic [7:0] PARK_ROW   = 8'hFF;
  localparam logic [7:0] PARKED_ROW = 8'd24;
  localparam logic [7:0] PARKED_COL = 8'd79;
  localparam logic [7:0] COLOUR_MASK = 8'h0F;
  localparam logic [3:0] GRAY_TWO   = 4'd12;
  localparam logic [7:0] CREDIT_RESET = 8'd64;
  localparam logic [7:0] GLYPH_ROWS = 8'd8;

  localparam logic [7:0] RING_R = 8'h52;
  localparam logic [7:0] RING_I = 8'h49;
  localparam logic [7:0] RING_N = 8'h4E;
  localparam logic [7:0] RING_G = 8'h47;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] attribute;
    logic [7:0] length;
    logic [7:0] symbol;
    logic [7:0] glyph_code;
    logic [7:0] position;
    logic       command_done;
    logic       last;
  } result_t;

  // up to three results per byte, decided in the front part
  typedef struct packed {
    logic [2:0] valid;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } batch_t;

  function automatic result_t blank(input logic [3:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

endpackage

>>> rtl/tcsd_if.sv
// tcsd_in_if / tcsd_out_if: valid/ready channels of the decoder
// no dependencies
`timescale 1ns / 1ps
interface tcsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  modport source (output valid, op, rx_byte, input ready);
  modport sink (input valid, op, rx_byte, output ready);
endinterface

interface tcsd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] row;
  logic [7:0] column;
  logic [7:0] attribute;
  logic [7:0] length;
  logic [7:0] symbol;
  logic [7:0] glyph_code;
  logic [7:0] position;
  logic       command_done;
  logic       last;
  modport source (output valid, kind, row, column, attribute, length, symbol,
                  glyph_code, position, command_done, last, input ready);
  modport sink (input valid, kind, row, column, attribute, length, symbol,
                glyph_code, position, command_done, last, output ready);
endinterface

>>> rtl/terminal_command_stream_decoder_core.sv
// terminal_command_stream_decoder_core: top level of the decoder
// depends on tcsd_pkg, tcsd_if, tcsd_front, tcsd_back
//
// channel   dir   handshake      payload
// in        sink  valid/ready    op, rx_byte
// out       src   valid/ready    kind..last
// cfg       in    cfg_we         cfg_wdata = credit period
//
// one input byte is taken per cycle while the batch queue has room
// each result is one transfer on out, so a byte yields 0 to 3 results
// the 4-entry batch queue lets the parser run ahead of a stalled output
// rst is synchronous and clears all parser state and the queue
`timescale 1ns / 1ps
module terminal_command_stream_decoder_core import tcsd_pkg::*; #(
  parameter int PANEL_ROWS = 25,
  parameter int PANEL_COLS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  tcsd_in_if.sink    in,
  tcsd_out_if.source out
);

  logic    b_valid, b_ready;
  batch_t  b_data;
  result_t r;

  tcsd_front #(.PANEL_ROWS(PANEL_ROWS), .PANEL_COLS(PANEL_COLS)) u_front (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid(in.valid), .in_ready(in.ready), .in_op(in.op), .in_byte(in.rx_byte),
    .b_valid, .b_ready, .b_data
  );

  tcsd_back u_back (
    .clk, .rst, .b_valid, .b_ready, .b_data,
    .o_valid(out.valid), .o_ready(out.ready), .o_data(r)
  );

  assign out.kind = r.kind;
  assign out.row = r.row;
  assign out.column = r.column;
  assign out.attribute = r.attribute;
  assign out.length = r.length;
  assign out.symbol = r.symbol;
  assign out.glyph_code = r.glyph_code;
  assign out.position = r.position;
  assign out.command_done = r.command_done;
  assign out.last = r.last;

endmodule

>>> rtl/tcsd_front.sv
// tcsd_front: parser state; turns one input item into a batch of results
// depends on tcsd_pkg
`timescale 1ns / 1ps
module tcsd_front import tcsd_pkg::*; #(
  parameter int PANEL_ROWS = 25,
  parameter int PANEL_COLS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_byte,
  output logic       b_valid,
  input  logic       b_ready,
  output batch_t     b_data
);

  typedef enum logic [2:0] {PH_OPCODE, PH_HEADER, PH_RUN, PH_PANEL, PH_GLYPH} phase_t;

  phase_t     parse_phase, phase_next;
  logic [7:0] credit_period;
  logic [7:0] command_code, cmd_next;
  logic [7:0] header_bytes [4];
  logic [7:0] hb_next [4];
  logic [2:0] header_count, hc_next;
  logic [2:0] header_needed, hn_next;
  logic [7:0] payload_needed, pn_next;
  logic [7:0] payload_count, pc_next;
  logic [7:0] panel_line, pl_next;
  logic [3:0] panel_colour, pcol_next;
  logic       panel_claimed, claimed_next;
  logic       resync_cooldown, cool_next;
  logic [2:0] ring_progress, ring_next;
  logic [7:0] credit_count, cc_next;

  result_t    res [3];
  logic [1:0] n;
  logic       accept;

  assign in_ready = !b_valid || b_ready;
  assign accept = in_valid && in_ready;

  function automatic logic [7:0] ring_at(input logic [1:0] i);
    case (i)
      2'd0: return RING_R;
      2'd1: return RING_I;
      2'd2: return RING_N;
      default: return RING_G;
    endcase
  endfunction

  always_comb begin
    result_t    r;
    logic [7:0] idx, cnt1;
    logic       done, answered;
    logic [2:0] hcnt;
    phase_next = parse_phase; cmd_next = command_code;
    hb_next = header_bytes; hc_next = header_count; hn_next = header_needed;
    pn_next = payload_needed; pc_next = payload_count; pl_next = panel_line;
    pcol_next = panel_colour; claimed_next = panel_claimed;
    cool_next = resync_cooldown; ring_next = ring_progress; cc_next = credit_count;
    res[0] = '0; res[1] = '0; res[2] = '0; n = 2'd0;
    answered = 1'b0; r = '0; idx = '0; cnt1 = '0; done = 1'b0; hcnt = '0;
    case (in_op)
      OP_BYTE: begin
        cc_next = credit_count + 8'd1;
        if (cc_next >= credit_period) begin
          cc_next = '0;
          r = blank(K_CONTROL); r.symbol = CTL_CREDIT;
          res[n] = r; n = n + 2'd1;
        end
        if (parse_phase == PH_OPCODE) begin
          if (in_byte == ring_at(ring_progress[1:0])) begin
            ring_next = ring_progress + 3'd1;
            if (ring_next >= 3'd4) begin
              ring_next = '0;
              res[n] = blank(K_ANSWER); n = n + 2'd1;
              answered = 1'b1;
            end
          end else begin
            ring_next = (in_byte == RING_R) ? 3'd1 : 3'd0;
          end
        end
        case (parse_phase)
          PH_HEADER: begin
            if (!header_count[2]) hb_next[header_count[1:0]] = in_byte;
            hcnt = header_count + 3'd1;
            hc_next = hcnt;
            if (hcnt >= header_needed) begin
              phase_next = PH_OPCODE;
              case (command_code)
                OPC_CLEAR: begin
                  r = blank(K_CLEAR); r.attribute = hb_next[0];
                  res[n] = r; n = n + 2'd1;
                end
                OPC_RUN: begin
                  pn_next = hb_next[3];
                  if (pn_next != 0) phase_next = PH_RUN;
                end
                OPC_FILL: begin
                  r = blank(K_FILL); r.row = hb_next[0]; r.column = hb_next[1];
                  r.attribute = hb_next[2]; r.length = hb_next[3]; r.symbol = in_byte;
                  res[n] = r; n = n + 2'd1;
                end
                OPC_CURSOR: begin
                  r = blank(K_CURSOR);
                  if (hb_next[0] == PARK_ROW) begin
                    r.row = PARKED_ROW; r.column = PARKED_COL;
                  end else begin
                    r.row = hb_next[0]; r.column = hb_next[1];
                  end
                  res[n] = r; n = n + 2'd1;
                end
                OPC_GLYPH: begin
                  pn_next = GLYPH_ROWS; phase_next = PH_GLYPH;
                end
                OPC_PANEL: begin
                  if (!panel_claimed) begin
                    claimed_next = 1'b1;
                    res[n] = blank(K_CLAIM); n = n + 2'd1;
                  end
                  pl_next = hb_next[0];
                  pcol_next = 4'(hb_next[1] & COLOUR_MASK);
                  pn_next = hb_next[2];
                  if (pn_next != 0) phase_next = PH_PANEL;
                end
                OPC_BYE: begin
                  if (in_byte == BYE_KEY) begin
                    res[n] = blank(K_SHUT); n = n + 2'd1;
                  end
                end
                default: ;
              endcase
            end
          end
          PH_RUN, PH_PANEL, PH_GLYPH: begin
            idx = payload_count;
            cnt1 = payload_count + 8'd1;
            pc_next = cnt1;
            done = (parse_phase == PH_GLYPH) ? (cnt1 >= GLYPH_ROWS)
                                             : (cnt1 >= payload_needed);
            r = '0; r.symbol = in_byte; r.position = idx; r.command_done = done;
            if (parse_phase == PH_RUN) begin
              r.kind = K_RUN; r.row = header_bytes[0]; r.column = header_bytes[1];
              r.attribute = header_bytes[2]; r.length = payload_needed;
              res[n] = r; n = n + 2'd1;
            end else if (parse_phase == PH_GLYPH) begin
              r.kind = K_GLYPH; r.glyph_code = header_bytes[0];
              res[n] = r; n = n + 2'd1;
            end else if (32'(panel_line) < PANEL_ROWS && 32'(idx) < PANEL_COLS) begin
              r.kind = K_PCELL; r.row = panel_line; r.column = idx;
              r.attribute = {4'd0, panel_colour};
              res[n] = r; n = n + 2'd1;
            end
            if (done) phase_next = PH_OPCODE;
          end
          default: begin
            phase_next = PH_OPCODE;
            cmd_next = in_byte; hc_next = '0; pc_next = '0;
            case (in_byte)
              OPC_CLEAR, OPC_BYE, OPC_GLYPH: begin hn_next = 3'd1; phase_next = PH_HEADER; end
              OPC_RUN:    begin hn_next = 3'd4; phase_next = PH_HEADER; end
              OPC_FILL:   begin hn_next = 3'd5; phase_next = PH_HEADER; end
              OPC_CURSOR, OPC_HELLO: begin hn_next = 3'd2; phase_next = PH_HEADER; end
              OPC_PANEL:  begin hn_next = 3'd3; phase_next = PH_HEADER; end
              OPC_FRAME: begin
                cool_next = 1'b0;
                res[n] = blank(K_FRAME); n = n + 2'd1;
              end
              OPC_BELL: begin res[n] = blank(K_BELL); n = n + 2'd1; end
              default: begin
                if (!resync_cooldown) begin
                  cool_next = 1'b1;
                  r = blank(K_CONTROL); r.symbol = CTL_RESYNC;
                  res[n] = r; n = n + 2'd1;
                end
              end
            endcase
          end
        endcase
        if (answered) phase_next = PH_OPCODE;
      end
      OP_IDLE: phase_next = PH_OPCODE;
      OP_RESYNC: begin
        phase_next = PH_OPCODE; ring_next = '0;
        r = blank(K_CONTROL); r.symbol = CTL_RESYNC;
        res[0] = r; n = 2'd1;
      end
      default: ;
    endcase
    if (n != 0) res[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_OPCODE; command_code <= '0;
      for (int i = 0; i < 4; i++) header_bytes[i] <= '0;
      header_count <= '0; header_needed <= '0; payload_needed <= '0;
      payload_count <= '0; panel_line <= '0; panel_colour <= GRAY_TWO;
      panel_claimed <= 1'b0; resync_cooldown <= 1'b0; ring_progress <= '0;
      credit_count <= '0; credit_period <= CREDIT_RESET; b_valid <= 1'b0;
    end else begin
      if (cfg_we) credit_period <= cfg_wdata;
      if (accept) begin
        parse_phase <= phase_next; command_code <= cmd_next;
        header_bytes <= hb_next; header_count <= hc_next;
        header_needed <= hn_next; payload_needed <= pn_next;
        payload_count <= pc_next; panel_line <= pl_next;
        panel_colour <= pcol_next; panel_claimed <= claimed_next;
        resync_cooldown <= cool_next; ring_progress <= ring_next;
        credit_count <= cc_next;
        b_valid <= (n != 0);
        b_data.valid <= {n == 2'd3, n >= 2'd2, n >= 2'd1};
        b_data.r0 <= res[0]; b_data.r1 <= res[1]; b_data.r2 <= res[2];
      end else if (b_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  // ring progress never passes the last letter
  a_ring: assert property (@(posedge clk) disable iff (rst) ring_progress < 3'd4)
    else $error("ring progress out of range");
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_HEADER |-> header_needed != 0)
    else $error("header phase with no header");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_ready |=> b_valid && $stable(b_data))
    else $error("batch lost while stalled");

endmodule

>>> rtl/tcsd_back.sv
// tcsd_back: batch queue and serializer onto the result channel
// depends on tcsd_pkg
`timescale 1ns / 1ps
module tcsd_back import tcsd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    b_valid,
  output logic    b_ready,
  input  batch_t  b_data,
  output logic    o_valid,
  input  logic    o_ready,
  output result_t o_data
);

  localparam int AW = $clog2(QDEPTH);

  batch_t      q [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic [1:0]    sel;
  logic          pop, push, last_of;

  assign b_ready = cnt != (AW+1)'(QDEPTH);
  assign push = b_valid && b_ready;
  assign o_valid = cnt != 0;

  always_comb begin
    case (sel)
      2'd0: o_data = q[rp].r0;
      2'd1: o_data = q[rp].r1;
      default: o_data = q[rp].r2;
    endcase
  end

  assign last_of = (sel == 2'd2) || !q[rp].valid[sel + 2'd1];
  assign pop = o_valid && o_ready && last_of;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= b_data;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; sel <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (o_valid && o_ready) sel <= last_of ? 2'd0 : sel + 2'd1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= (AW+1)'(QDEPTH))
    else $error("queue overflow");
  a_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_ready && last_of |-> o_data.last)
    else $error("batch ends without last");

endmodule
